/* rtl/hmm_scaled_forward_macros.svh */
// Assertion macros for the scaled HMM forward block.
// Used by the top level only; no other dependencies.
`ifndef HMM_SCALED_FORWARD_MACROS_SVH
`define HMM_SCALED_FORWARD_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hmm_scaled_forward check failed");

// Next-cycle implication checked outside reset.
`define HSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hmm_scaled_forward check failed");

`endif

/* rtl/hsf_pkg.sv */
// Shared constants and types for the scaled HMM forward block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsf_pkg;
   localparam int MaxStates   = 8;
   localparam int NumSymbols  = 16;
   localparam int StW         = $clog2(MaxStates);
   localparam int SymW        = $clog2(NumSymbols);
   localparam int ProbW       = 17;
   localparam int SumW        = 24;
   localparam int LlW         = 32;
   localparam int TransDepth  = MaxStates * MaxStates;
   localparam int EmitDepth   = MaxStates * NumSymbols;
   localparam int TransAw     = $clog2(TransDepth);
   localparam int EmitAw      = $clog2(EmitDepth);
   localparam logic [31:0] Ln2Q32 = 32'd2977044472;

   localparam logic [1:0] KIND_TRANS = 2'd0;
   localparam logic [1:0] KIND_EMIT  = 2'd1;
   localparam logic [1:0] KIND_INIT  = 2'd2;
   localparam logic [1:0] KIND_OBS   = 2'd3;

   // Request to the arithmetic datapath.
   typedef struct packed {
      logic                first;
      logic [SymW-1:0]     sym;
   } step_req_type;
endpackage
`default_nettype wire

/* rtl/hsf_ram.sv */
// Generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hsf_ram #(
   parameter int Width = 17,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/hsf_divider.sv */
// Restoring divider, one quotient bit per cycle: (num*65536 + den/2) / den.
// Depends on hsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsf_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [hsf_pkg::SumW-1:0]   num,
   input  wire logic [hsf_pkg::SumW-1:0]   den,
   output logic                            done,
   output logic      [hsf_pkg::ProbW-1:0]  quot
);
   localparam int DividendW = hsf_pkg::SumW + 17;
   localparam int CntW = $clog2(DividendW + 1);

   logic [DividendW-1:0]       dvd_ff, dvd_in;
   logic [hsf_pkg::SumW:0]     rem_ff, rem_in;
   logic [hsf_pkg::SumW-1:0]   den_ff;
   logic [DividendW-1:0]       q_ff, q_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [hsf_pkg::SumW:0]     trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[hsf_pkg::SumW-1:0], dvd_ff[DividendW-1]};
      if (start) begin
         dvd_in  = {1'b0, num, 16'd0} + DividendW'({1'b0, den} >> 1);
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CntW'(DividendW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DividendW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[DividendW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[DividendW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = q_ff[hsf_pkg::ProbW-1:0];
endmodule
`default_nettype wire

/* rtl/hsf_log.sv */
// Natural log of x/65536 in Q16.16 by iterative squaring, one bit per step.
// Depends on hsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsf_log (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [hsf_pkg::SumW-1:0] x,
   output logic                          done,
   output logic signed [hsf_pkg::LlW-1:0] ln_out
);
   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_MSB  = 3'd1;
   localparam logic [2:0] L_SQ   = 3'd2;
   localparam logic [2:0] L_MUL  = 3'd3;
   localparam logic [2:0] L_DONE = 3'd4;
   localparam int LlWt = 22;

   logic [2:0]  st_ff, st_in;
   logic [4:0]  k_ff, k_in;
   logic [31:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  bit_ff, bit_in;
   logic [23:0] x_ff;
   logic signed [LlWt-1:0] l2;
   logic [LlWt-1:0] mag_l2;
   logic [63:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   logic [63:0] sq;
   logic [4:0]  kk;
   logic signed [hsf_pkg::LlW-1:0] res_ff, res_in;

   always_comb begin
      kk = '0;
      for (int b = 0; b < hsf_pkg::SumW; b++) begin
         if (x_ff[b]) begin
            kk = 5'(b);
         end
      end
   end

   assign sq = 64'(m_ff) * 64'(m_ff);
   assign l2 = LlWt'(signed'({1'b0, k_ff})) * 22'sd65536 - 22'sd1048576
             + LlWt'(signed'({1'b0, frac_ff}));
   assign mag_l2 = l2[LlWt-1] ? LlWt'(-l2) : LlWt'(l2);

   always_comb begin
      st_in   = st_ff;
      k_in    = k_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      bit_in  = bit_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      unique case (st_ff)
         L_IDLE: begin
            if (start) begin
               st_in = L_MSB;
            end
         end
         L_MSB: begin
            k_in    = kk;
            m_in    = 32'({8'd0, x_ff} << (5'd30 - kk));
            frac_in = '0;
            bit_in  = 5'd15;
            st_in   = L_SQ;
         end
         L_SQ: begin
            if (sq[61]) begin
               m_in = sq[62:31];
               frac_in = frac_ff | (16'd1 << bit_ff[3:0]);
            end else begin
               m_in = sq[61:30];
            end
            if (bit_ff == 5'd0) begin
               st_in = L_MUL;
            end else begin
               bit_in = bit_ff - 5'd1;
            end
         end
         L_MUL: begin
            neg_in  = l2[LlWt-1];
            prod_in = 64'(mag_l2) * 64'(hsf_pkg::Ln2Q32) + 64'h8000_0000;
            st_in   = L_DONE;
         end
         L_DONE: begin
            res_in = neg_ff ? -signed'(prod_ff[63:32]) : signed'(prod_ff[63:32]);
            st_in  = L_IDLE;
         end
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= L_IDLE;
      end else begin
         st_ff <= st_in;
      end
      k_ff    <= k_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      bit_ff  <= bit_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      if (start) begin
         x_ff <= x;
      end
   end

   assign done   = (st_ff == L_DONE);
   assign ln_out = res_in;
endmodule
`default_nettype wire

/* rtl/hmm_scaled_forward.sv */
// Scaled HMM forward block: tables in RAM, sequencer, divider, log unit.
// A continuing observation word sums N products per state for N states, one
// multiply-accumulate per RAM read; a starting one skips the sum of products. Each
// normalization runs a bit-serial 41-bit divide, and the log runs sixteen squaring
// steps. A zero sum skips the divides and the log. A load word passes through S_LOAD
// and back to idle. One word is in work at a time; an observation waits at its end
// while the previous result still sits untaken in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "hmm_scaled_forward_macros.svh"
module hmm_scaled_forward (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_states_in_use,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [2:0]  req_row_index,
   input  wire logic [3:0]  req_column_index,
   input  wire logic [16:0] req_prob_value,
   input  wire logic [3:0]  req_symbol,
   input  wire logic        req_first_obs,
   input  wire logic        req_last_obs,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_log_likelihood,
   output logic             rsp_sequence_done,
   output logic             rsp_zero_scale_error
);
   localparam int StW  = hsf_pkg::StW;
   localparam int PW   = hsf_pkg::ProbW;
   localparam int SW   = hsf_pkg::SumW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_JINIT = 4'd2;
   localparam logic [3:0] S_MAC   = 4'd3;
   localparam logic [3:0] S_MACW  = 4'd4;
   localparam logic [3:0] S_EMUL  = 4'd5;
   localparam logic [3:0] S_TERM  = 4'd6;
   localparam logic [3:0] S_NRM   = 4'd7;
   localparam logic [3:0] S_NRMR  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_LOG   = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;
   localparam logic [3:0] S_LWAIT = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [3:0]  siu_ff;
   logic [StW:0] n_eff;
   hsf_pkg::step_req_type cmd_ff;
   logic        last_ff;
   logic [1:0]  kind_ff;
   logic [2:0]  row_ff;
   logic [3:0]  col_ff;
   logic [PW-1:0] pv_ff;
   logic [StW-1:0] j_ff, j_in, i_ff, i_in;
   logic [StW:0]   cnt_ff, cnt_in;
   logic [PW+PW+StW-1:0] acc_ff, acc_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [33:0]   prod_ff;
   logic          err_ff, err_in;
   logic signed [31:0] ll_ff, ll_in;
   logic          rv_ff, rv_in;
   logic          rdone_ff, rdone_in, rerr_ff, rerr_in;
   logic signed [31:0] rll_ff, rll_in;

   // RAM ports
   logic tr_we, em_we, in_we, fw_we, un_we;
   logic [hsf_pkg::TransAw-1:0] tr_wa, tr_ra;
   logic [hsf_pkg::EmitAw-1:0]  em_wa, em_ra;
   logic [StW-1:0] in_wa, in_ra, fw_wa, fw_ra, un_wa, un_ra;
   logic [PW-1:0] tr_rd, em_rd, in_rd, fw_rd, fw_wd;
   logic [SW-1:0] un_rd, un_wd;
   logic          symok_ff;

   logic div_start, div_done, log_start, log_done;
   logic [PW-1:0] div_q;
   logic signed [31:0] ln_val;
   logic [SW:0] sum_sat;
   logic [33:0] prod_now;
   logic [2*PW-1:0]      mac_prod;
   logic [PW+PW+StW-1:0] mac_sum;
   logic [PW+StW+1:0]    acc_rnd;
   logic [38:0]          emul;
   logic signed [32:0]   ll_tot;

   assign n_eff = (siu_ff == 4'd0) ? (StW+1)'(1)
                : (siu_ff > 4'(hsf_pkg::MaxStates)) ? (StW+1)'(hsf_pkg::MaxStates)
                : (StW+1)'(siu_ff);

   hsf_ram #(.Width(PW), .Depth(hsf_pkg::TransDepth)) u_tr (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(pv_ff),
      .rd_addr(tr_ra), .rd_data(tr_rd));
   hsf_ram #(.Width(PW), .Depth(hsf_pkg::EmitDepth)) u_em (
      .clock(clock), .wr_en(em_we), .wr_addr(em_wa), .wr_data(pv_ff),
      .rd_addr(em_ra), .rd_data(em_rd));
   hsf_ram #(.Width(PW), .Depth(hsf_pkg::MaxStates)) u_in (
      .clock(clock), .wr_en(in_we), .wr_addr(in_wa), .wr_data(pv_ff),
      .rd_addr(in_ra), .rd_data(in_rd));
   hsf_ram #(.Width(PW), .Depth(hsf_pkg::MaxStates)) u_fw (
      .clock(clock), .wr_en(fw_we), .wr_addr(fw_wa), .wr_data(fw_wd),
      .rd_addr(fw_ra), .rd_data(fw_rd));
   hsf_ram #(.Width(SW), .Depth(hsf_pkg::MaxStates)) u_un (
      .clock(clock), .wr_en(un_we), .wr_addr(un_wa), .wr_data(un_wd),
      .rd_addr(un_ra), .rd_data(un_rd));

   hsf_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(un_rd),
      .den(sum_ff), .done(div_done), .quot(div_q));
   hsf_log u_log (
      .clock(clock), .reset(reset), .start(log_start), .x(sum_ff),
      .done(log_done), .ln_out(ln_val));

   // Table writes
   assign tr_we = (st_ff == S_LOAD) && (kind_ff == hsf_pkg::KIND_TRANS) && !col_ff[3];
   assign em_we = (st_ff == S_LOAD) && (kind_ff == hsf_pkg::KIND_EMIT);
   assign in_we = (st_ff == S_LOAD) && (kind_ff == hsf_pkg::KIND_INIT);
   assign tr_wa = {row_ff, col_ff[StW-1:0]};
   assign em_wa = {row_ff, col_ff};
   assign in_wa = row_ff;

   // Reads: transition A[i][j], forward alpha[i], emission B[j][sym], init pi[j]
   assign tr_ra = {i_ff, j_ff};
   assign fw_ra = i_ff;
   assign em_ra = {j_ff, cmd_ff.sym};
   assign in_ra = j_ff;
   assign un_ra = j_ff;

   // Only new forward vars are written once all MACs are done (normalization).
   assign fw_we = ((st_ff == S_DIV) && div_done) || ((st_ff == S_NRM) && (sum_ff == '0));
   assign fw_wa = j_ff;
   assign fw_wd = (sum_ff == '0) ? '0 : div_q;

   assign un_we = (st_ff == S_TERM);
   assign un_wa = j_ff;
   assign un_wd = (prod_ff > 34'hFFFFFF) ? 24'hFFFFFF : prod_ff[SW-1:0];

   assign mac_prod = tr_rd * fw_rd;
   assign mac_sum  = acc_ff + (PW+PW+StW)'(mac_prod);
   assign acc_rnd  = (PW+StW+2)'((acc_ff + (PW+PW+StW)'(16'h8000)) >> 16);
   assign emul     = 39'(acc_rnd) * 39'(symok_ff ? em_rd : '0);
   assign prod_now = 34'((emul + 39'h8000) >> 16);
   assign sum_sat  = {1'b0, sum_ff} + {1'b0, un_wd};
   assign ll_tot   = 33'(ll_ff) + 33'(ln_val);

   assign div_start = (st_ff == S_NRMR) && !err_ff;
   assign log_start = (st_ff == S_LOG) && !err_ff;

   always_comb begin
      st_in   = st_ff;
      j_in    = j_ff;
      i_in    = i_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sum_in  = sum_ff;
      err_in  = err_ff;
      ll_in   = ll_ff;
      rv_in   = rv_ff;
      rdone_in = rdone_ff;
      rerr_in  = rerr_ff;
      rll_in   = rll_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               st_in = (req_kind == hsf_pkg::KIND_OBS) ? S_JINIT : S_LOAD;
               j_in  = '0;
               i_in  = '0;
               sum_in = '0;
            end
         end
         S_LOAD: st_in = S_IDLE;
         S_JINIT: begin
            // read issued for i=0 this cycle; pi/B for j
            acc_in = '0;
            i_in   = '0;
            cnt_in = '0;
            st_in  = cmd_ff.first ? S_MACW : S_MAC;
         end
         S_MAC: begin
            // pipeline: data for previous i arrives; cnt counts received terms
            if (cnt_ff != '0) begin
               acc_in = mac_sum;
            end
            if (cnt_ff == n_eff) begin
               st_in = S_EMUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (i_ff != StW'(n_eff - 1'b1)) begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         S_MACW: begin
            acc_in = (PW+PW+StW)'(in_rd) << 16;
            st_in  = S_EMUL;
         end
         S_EMUL: begin
            st_in = S_TERM;
         end
         S_TERM: begin
            sum_in = sum_sat[SW] ? {SW{1'b1}} : sum_sat[SW-1:0];
            i_in   = '0;
            if (j_ff == StW'(n_eff - 1'b1)) begin
               j_in  = '0;
               st_in = S_NRM;
               err_in = 1'b0;
            end else begin
               j_in  = j_ff + 1'b1;
               st_in = S_JINIT;
            end
         end
         S_NRM: begin
            err_in = (sum_ff == '0);
            if (sum_ff == '0) begin
               if (j_ff == StW'(n_eff - 1'b1)) begin
                  st_in = S_LOG;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               st_in = S_NRMR;
            end
         end
         S_NRMR: st_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               if (j_ff == StW'(n_eff - 1'b1)) begin
                  st_in = S_LOG;
               end else begin
                  j_in  = j_ff + 1'b1;
                  st_in = S_NRM;
               end
            end
         end
         S_LOG: begin
            if (cmd_ff.first) begin
               ll_in = '0;
            end
            st_in = err_ff ? S_OUT : S_LWAIT;
         end
         S_LWAIT: begin
            if (log_done) begin
               if (ll_tot > 33'sh0_7FFF_FFFF) begin
                  ll_in = 32'sh7FFF_FFFF;
               end else if (ll_tot < -33'sh0_8000_0000) begin
                  ll_in = 32'sh8000_0000;
               end else begin
                  ll_in = ll_tot[31:0];
               end
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_in) begin
               rv_in    = 1'b1;
               rll_in   = ll_ff;
               rdone_in = last_ff;
               rerr_in  = err_ff;
               st_in    = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         siu_ff  <= 4'd8;
         ll_ff   <= '0;
         rv_ff   <= 1'b0;
         err_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         st_ff  <= st_in;
         ll_ff  <= ll_in;
         rv_ff  <= rv_in;
         err_ff <= err_in;
         cnt_ff <= cnt_in;
         if (csr_write_enable) begin
            siu_ff <= csr_states_in_use;
         end
      end
      j_ff    <= j_in;
      i_ff    <= i_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
      rll_ff  <= rll_in;
      rdone_ff <= rdone_in;
      rerr_ff <= rerr_in;
      if (st_ff == S_EMUL) begin
         prod_ff <= prod_now;
      end
      if (st_ff == S_IDLE && req_valid) begin
         cmd_ff.first <= req_first_obs;
         cmd_ff.sym   <= req_symbol;
         symok_ff     <= (5'(req_symbol) < 5'(hsf_pkg::NumSymbols));
         last_ff <= req_last_obs;
         kind_ff <= req_kind;
         row_ff  <= req_row_index;
         col_ff  <= req_column_index;
         pv_ff   <= req_prob_value;
      end
   end

   assign req_ready            = (st_ff == S_IDLE);
   assign rsp_valid            = rv_ff;
   assign rsp_log_likelihood   = rll_ff;
   assign rsp_sequence_done    = rdone_ff;
   assign rsp_zero_scale_error = rerr_ff;

   `HSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `HSF_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, st_ff == S_IDLE)
   `HSF_ASSERT_NEXT(a_load_no_rsp, clock, reset, st_ff == S_LOAD, st_ff == S_IDLE)
endmodule
`default_nettype wire
